// ===== rtl/core/qseh_pkg.sv =====
// Shared types, constants and base-decoding functions for the error histogram.
package qseh_pkg;

  localparam int READ_LEN     = 128;
  localparam int MAX_PHRED    = 60;
  localparam int COUNT_BITS   = 32;
  localparam int PHRED_LEVELS = MAX_PHRED + 1;
  localparam int CELL_SIZE    = 20;
  localparam int BASE_STRIDE  = 5;
  localparam int STORE_DEPTH  = READ_LEN * PHRED_LEVELS * CELL_SIZE;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int ROW_W        = $clog2(READ_LEN * PHRED_LEVELS);
  localparam int FILL_LAST    = 15;

  localparam logic [2:0] BASE_A   = 3'd0;
  localparam logic [2:0] BASE_C   = 3'd1;
  localparam logic [2:0] BASE_G   = 3'd2;
  localparam logic [2:0] BASE_T   = 3'd3;
  localparam logic [2:0] BASE_N   = 3'd4;
  localparam logic [2:0] BASE_BAD = 3'd5;

  localparam logic OP_COUNT = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef enum logic [1:0] {
    CFG_QUALITY_OFFSET = 2'd0,
    CFG_ACTIVE_LENGTH  = 2'd1
  } cfg_index_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_RD_AA,
    S_WAIT_AA,
    S_FILL,
    S_RD_T,
    S_WAIT_T
  } state_t;

  typedef struct packed {
    logic                  we;
    logic [ADDR_W-1:0]     addr;
    logic [COUNT_BITS-1:0] wdata;
  } mem_req_t;

  function automatic logic [2:0] base_code(input logic [7:0] ch);
    logic [7:0] u;
    logic [2:0] code;
    u = (ch >= 8'h61 && ch <= 8'h7a) ? ch - 8'd32 : ch;
    case (u)
      8'h41:   code = BASE_A;
      8'h43:   code = BASE_C;
      8'h47:   code = BASE_G;
      8'h54:   code = BASE_T;
      8'h4e:   code = BASE_N;
      default: code = BASE_BAD;
    endcase
    return code;
  endfunction

  function automatic logic [2:0] complement_code(input logic [2:0] code);
    return (code < BASE_N) ? 3'(BASE_T - code) : BASE_N;
  endfunction

endpackage

// ===== rtl/core/qseh_counter_ram.sv =====
// Counter store: single-port memory with registered read data.
module qseh_counter_ram
  import qseh_pkg::*;
(
  input  logic                  clk,
  input  mem_req_t              req,
  output logic [COUNT_BITS-1:0] rd_data
);

  logic [COUNT_BITS-1:0] mem [STORE_DEPTH];
  logic [COUNT_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rd_data_r <= mem[req.addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/quality_stratified_error_histogram.sv =====
// Top level of the quality-stratified base-pair error histogram.
//
//   channel | direction | handshake              | payload
//   in_     | input     | in_valid / in_ready    | operation, position, chars, strand, query
//   out_    | output    | out_valid / out_ready  | count_value, cell_touched, skipped, range_error
//   cfg_    | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A count item on the first touch of a cell also writes the sixteen pseudocounts.
// The single port of the counter memory takes one access per cycle.
// After reset a clearing pass writes zero to all 156160 counters, one per cycle; in_ready
// stays low meanwhile, while configuration writes are taken at any time.
// One item is in work at a time; the result waits in the output register for out_ready.
module quality_stratified_error_histogram
  import qseh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [6:0]  in_position,
  input  logic [7:0]  in_quality_char,
  input  logic [7:0]  in_ref_char,
  input  logic [7:0]  in_read_char,
  input  logic        in_strand_bit,
  input  logic [5:0]  in_query_phred,
  input  logic [1:0]  in_query_ref,
  input  logic [2:0]  in_query_read,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_count_value,
  output logic        out_cell_touched,
  output logic        out_skipped,
  output logic        out_range_error,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  state_t state_r, state_nxt;

  logic        op_r, strand_r;
  logic [6:0]  pos_r;
  logic [7:0]  qch_r, refc_r, readc_r;
  logic [5:0]  qp_r;
  logic [1:0]  qr_r;
  logic [2:0]  qd_r;

  logic [6:0]  qoff_r;
  logic [7:0]  act_len_r;

  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [4:0]        off_r, off_nxt;
  logic [3:0]        fill_r, fill_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;

  logic [COUNT_BITS-1:0] res_value_r, res_value_nxt;
  logic res_touched_r, res_touched_nxt;
  logic res_skip_r, res_skip_nxt;
  logic res_err_r, res_err_nxt;

  logic        out_valid_r;
  logic [31:0] out_value_r;
  logic        out_touched_r, out_skip_r, out_err_r;
  logic        out_load;

  mem_req_t              mem_req;
  logic [COUNT_BITS-1:0] rd_data;

  logic        pos_ok, q_low, q_high, ref_bad, count_err, query_err;
  logic [7:0]  qdiff;
  logic [2:0]  rc_raw, dc_raw, rc, dc;
  logic [5:0]  phred_sel;
  logic [4:0]  off_sel;
  logic [ROW_W-1:0]  row;
  logic [ADDR_W-1:0] base_calc;

  qseh_counter_ram u_ram (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    pos_ok    = {1'b0, pos_r} < act_len_r;
    rc_raw    = base_code(refc_r);
    dc_raw    = base_code(readc_r);
    ref_bad   = rc_raw > BASE_T;
    if (dc_raw == BASE_BAD) begin
      dc_raw = BASE_N;
    end
    rc = strand_r ? rc_raw : complement_code(rc_raw);
    dc = strand_r ? dc_raw : complement_code(dc_raw);
    q_low     = qch_r < {1'b0, qoff_r};
    qdiff     = qch_r - {1'b0, qoff_r};
    q_high    = qdiff > 8'(MAX_PHRED);
    count_err = q_low || q_high;
    query_err = !pos_ok || qp_r > 6'(MAX_PHRED) || qd_r > BASE_N;
    phred_sel = (op_r == OP_READ) ? qp_r : qdiff[5:0];
    off_sel   = (op_r == OP_READ) ? 5'(qr_r) * 5'(BASE_STRIDE) + 5'(qd_r)
                                  : 5'(rc[1:0]) * 5'(BASE_STRIDE) + 5'(dc);
    row       = ROW_W'(pos_r) * ROW_W'(PHRED_LEVELS) + ROW_W'(phred_sel);
    base_calc = (ADDR_W'(row) << 4) + (ADDR_W'(row) << 2);
  end

  assign out_load = !out_valid_r || out_ready;

  always_comb begin
    state_nxt       = state_r;
    base_nxt        = base_r;
    off_nxt         = off_r;
    fill_nxt        = fill_r;
    clr_nxt         = clr_r;
    res_value_nxt   = res_value_r;
    res_touched_nxt = res_touched_r;
    res_skip_nxt    = res_skip_r;
    res_err_nxt     = res_err_r;
    mem_req.we      = 1'b0;
    mem_req.addr    = base_r + ADDR_W'(off_r);
    mem_req.wdata   = '0;
    unique case (state_r)
      S_CLEAR: begin
        mem_req.we   = 1'b1;
        mem_req.addr = clr_r;
        clr_nxt      = clr_r + 1'b1;
        if (clr_r == ADDR_W'(STORE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        res_value_nxt   = '0;
        res_touched_nxt = 1'b0;
        res_skip_nxt    = 1'b0;
        res_err_nxt     = 1'b0;
        base_nxt        = base_calc;
        off_nxt         = off_sel;
        fill_nxt        = '0;
        if (op_r == OP_READ) begin
          res_err_nxt = query_err;
          state_nxt   = query_err ? S_WAIT_T : S_RD_AA;
        end else if (!pos_ok) begin
          res_err_nxt = 1'b1;
          state_nxt   = S_WAIT_T;
        end else if (ref_bad) begin
          res_skip_nxt = 1'b1;
          state_nxt    = S_WAIT_T;
        end else if (count_err) begin
          res_err_nxt = 1'b1;
          state_nxt   = S_WAIT_T;
        end else begin
          state_nxt = S_RD_AA;
        end
      end
      S_RD_AA: begin
        mem_req.addr = base_r;
        state_nxt    = S_WAIT_AA;
      end
      S_WAIT_AA: begin
        if (op_r == OP_READ) begin
          res_touched_nxt = (rd_data != '0);
          state_nxt       = S_RD_T;
        end else begin
          state_nxt = (rd_data == '0) ? S_FILL : S_RD_T;
        end
      end
      S_FILL: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = base_r + ADDR_W'(5'(fill_r[3:2]) * 5'(BASE_STRIDE) + 5'(fill_r[1:0]));
        mem_req.wdata = COUNT_BITS'(1);
        fill_nxt      = fill_r + 1'b1;
        if (fill_r == 4'(FILL_LAST)) begin
          state_nxt = S_RD_T;
        end
      end
      S_RD_T: begin
        state_nxt = S_WAIT_T;
      end
      S_WAIT_T: begin
        if (out_load) begin
          state_nxt = S_IDLE;
          if (!res_err_r && !res_skip_r) begin
            if (op_r == OP_READ) begin
              res_value_nxt = rd_data;
            end else begin
              mem_req.we    = 1'b1;
              mem_req.wdata = (rd_data == '1) ? rd_data : rd_data + 1'b1;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      qoff_r      <= 7'd33;
      act_len_r   <= 8'd128;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      if (state_r == S_WAIT_T && out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_QUALITY_OFFSET: qoff_r    <= cfg_data[6:0];
          CFG_ACTIVE_LENGTH:  act_len_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r     <= in_operation;
      pos_r    <= in_position;
      qch_r    <= in_quality_char;
      refc_r   <= in_ref_char;
      readc_r  <= in_read_char;
      strand_r <= in_strand_bit;
      qp_r     <= in_query_phred;
      qr_r     <= in_query_ref;
      qd_r     <= in_query_read;
    end
    base_r        <= base_nxt;
    off_r         <= off_nxt;
    fill_r        <= fill_nxt;
    res_value_r   <= res_value_nxt;
    res_touched_r <= res_touched_nxt;
    res_skip_r    <= res_skip_nxt;
    res_err_r     <= res_err_nxt;
    if (state_r == S_WAIT_T && out_load) begin
      out_value_r   <= res_value_nxt[31:0];
      out_touched_r <= res_touched_r;
      out_skip_r    <= res_skip_r;
      out_err_r     <= res_err_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_count_value  = out_value_r;
  assign out_cell_touched = out_touched_r;
  assign out_skipped      = out_skip_r;
  assign out_range_error  = out_err_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in work");

  a_write_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |-> mem_req.addr < ADDR_W'(STORE_DEPTH))
    else $error("counter write beyond the store");

  a_fill_in_cell: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FILL |-> mem_req.addr >= base_r && mem_req.addr < base_r + ADDR_W'(CELL_SIZE))
    else $error("pseudocount write outside its cell");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_skipped && out_range_error))
    else $error("skipped and range error both set");

  a_dropped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_skipped || out_range_error) |-> out_count_value == '0 && !out_cell_touched)
    else $error("dropped item returned a count");

endmodule
